>>> sv/pot_command_deadband_hysteresis_unit_defines.svh
// Assertion macros for the potentiometer command conditioner.
// Included by the top level; no other dependencies.
`ifndef POT_COMMAND_DEADBAND_HYSTERESIS_UNIT_DEFINES_SVH
`define POT_COMMAND_DEADBAND_HYSTERESIS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PCDH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcdh assertion failed");
// Next-cycle implication.
`define PCDH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcdh assertion failed");
`else
`define PCDH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PCDH_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/pcdh_pkg.sv
// Shared types and constants of the potentiometer command conditioner.
// No dependencies.
`default_nettype none
package pcdh_pkg;

  localparam int STEPS_PER_UNIT = 200;

  localparam int Q16_ONE    = 65536;
  localparam int IN_SCALE   = 16;
  localparam int MILLI      = 1000;
  localparam int HYST_WIDTH = 2;

  localparam int RAW_W   = 13;
  localparam int IN_TD_W = 16;
  localparam int OUT_W   = 9;
  localparam int OUT_TD_W = 16;
  localparam int DB_W    = 9;
  localparam int SAT_W   = 7;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;

  localparam int DB_RESET  = 100;
  localparam int SAT_RESET = 20;

  // Magnitude of x = 1 - raw/4096 in Q16, at most 1.0.
  localparam int X_W    = 17;
  localparam int FRAC_W = 16;
  // Divider: numerator up to 65536*1000, divisor up to 1000.
  localparam int NUM_W  = 26;
  localparam int DEN_W  = 10;
  localparam int DENS_W = 12;
  localparam int CNT_W  = $clog2(NUM_W);

  localparam int STEP_W = $clog2(STEPS_PER_UNIT + 1);
  localparam int MAG_W  = STEP_W + 1;
  localparam int PROD_W = X_W + STEP_W;
  localparam int CMP_W  = 11;

  localparam int STEP_MAX     = 255;
  localparam int STEP_MIN_MAG = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } step_mag_t;

endpackage
`default_nettype wire

>>> sv/pcdh_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pcdh_pkg.
`default_nettype none
module pcdh_serial_div
  import pcdh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo,
  output div_stat_t             stat
);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic             last;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};
  assign last    = busy_r && (cnt_r == CNT_W'(NUM_W - 1));

  always_comb begin
    rem_nxt = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      busy_r <= !last;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = last;

endmodule
`default_nettype wire

>>> sv/pcdh_shaper.sv
// Dead band removal, clamp to full scale and scaling into command steps.
// Depends on pcdh_pkg.
`default_nettype none
module pcdh_shaper
  import pcdh_pkg::*;
(
  input  wire logic [NUM_W-1:0] y_mag,
  input  wire logic [NUM_W-1:0] dbq,
  input  wire logic             neg,
  output step_mag_t             sm
);

  logic [NUM_W-1:0]  past_band;
  logic [X_W-1:0]    m_clamped;
  logic [PROD_W-1:0] prod;

  always_comb begin
    past_band = (y_mag < dbq) ? '0 : (y_mag - dbq);
    if (past_band > NUM_W'(Q16_ONE)) begin
      m_clamped = X_W'(Q16_ONE);
    end else begin
      m_clamped = past_band[X_W-1:0];
    end
  end

  assign prod   = PROD_W'(m_clamped) * PROD_W'(STEPS_PER_UNIT);
  assign sm.neg = neg;
  assign sm.mag = prod[PROD_W-1:FRAC_W];

endmodule
`default_nettype wire

>>> sv/pcdh_hyst.sv
// Step saturation, hysteresis against the held step, and held step update.
// Depends on pcdh_pkg.
`default_nettype none
module pcdh_hyst
  import pcdh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire step_mag_t        sm,
  input  wire logic             commit,
  output logic      [OUT_W-1:0] step_out
);

  logic signed [OUT_W-1:0] held_r, held_nxt;
  logic        [CMP_W-1:0] mag_ext;
  logic        [OUT_W-1:0] mag_sat;
  logic signed [OUT_W-1:0] step_s;
  logic signed [OUT_W:0]   diff;
  logic        [OUT_W:0]   abs_diff;
  logic        [OUT_W-1:0] chosen;

  always_comb begin
    mag_ext = CMP_W'(sm.mag);
    if (sm.neg) begin
      mag_sat = (mag_ext > CMP_W'(STEP_MIN_MAG)) ? OUT_W'(STEP_MIN_MAG) : OUT_W'(mag_ext);
      step_s  = $signed(OUT_W'(~mag_sat + 1'b1));
    end else begin
      mag_sat = (mag_ext > CMP_W'(STEP_MAX)) ? OUT_W'(STEP_MAX) : OUT_W'(mag_ext);
      step_s  = $signed(mag_sat);
    end
    diff     = {held_r[OUT_W-1], held_r} - {step_s[OUT_W-1], step_s};
    abs_diff = diff[OUT_W] ? (~diff + 1'b1) : diff;
    chosen   = (abs_diff < (OUT_W+1)'(HYST_WIDTH)) ? held_r : step_s;
    // Round toward zero to an even step.
    if (chosen[OUT_W-1] && chosen[0]) begin
      held_nxt = $signed(chosen + 1'b1);
    end else begin
      held_nxt = $signed({chosen[OUT_W-1:1], 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (commit) begin
      held_r <= held_nxt;
    end
  end

  assign step_out = chosen;

endmodule
`default_nettype wire

>>> sv/pot_command_deadband_hysteresis_unit.sv
// Potentiometer command conditioner: gain, dead band, clamp, 1/200 steps, hysteresis.
// Items are taken only in the idle state, once the previous item has been committed to
// the output register. Two 26-step bit-serial dividers form the gain quotient and the
// dead band threshold. Reset is synchronous, active low: clears control state,
// loads the dead band and saturation registers with 100 and 20, zeroes the held step.
// Depends on pcdh_pkg, pcdh_serial_div, pcdh_shaper, pcdh_hyst and the defines header.
`default_nettype none
`include "pot_command_deadband_hysteresis_unit_defines.svh"
module pot_command_deadband_hysteresis_unit
  import pcdh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input item
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_TD_W-1:0]   in_tdata,   // [12:0] raw_sum
  // Result item
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic      [OUT_TD_W-1:0]  out_tdata,  // [8:0] command_step
  // Configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [DB_W-1:0]  db_r;
  logic [SAT_W-1:0] sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_r  <= DB_W'(DB_RESET);
      sat_r <= SAT_W'(SAT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEAD_BAND:  db_r  <= cfg_wdata[DB_W-1:0];
        CFG_SATURATION: sat_r <= cfg_wdata[SAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  state_t state_r, state_nxt;
  logic   div_start;
  logic   scale_en;
  logic   commit;
  logic   out_valid_r;
  logic   out_free;

  div_stat_t y_stat, db_stat;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_DIV;
      ST_DIV:    if (y_stat.done) state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_COMMIT;
      ST_COMMIT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    scale_en  = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        div_start = in_tvalid;
      end
      ST_SCALE:  scale_en = 1'b1;
      ST_COMMIT: commit   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Front end: x = 1 - raw/4096 as sign and Q16 magnitude, times 1000,
  // and the gain denominator, floored at one.
  logic [RAW_W-1:0]       raw;
  logic [X_W:0]           raw_q16;
  logic                   x_neg;
  logic [X_W:0]           x_mag_w;
  logic [NUM_W-1:0]       y_num;
  logic signed [DENS_W-1:0] den_s;
  logic [DEN_W-1:0]       den;
  logic [NUM_W-1:0]       db_num;
  logic                   x_neg_r;

  assign raw     = in_tdata[RAW_W-1:0];
  assign raw_q16 = (X_W+1)'(raw) * (X_W+1)'(IN_SCALE);
  assign x_neg   = raw_q16 > (X_W+1)'(Q16_ONE);

  always_comb begin
    if (x_neg) begin
      x_mag_w = raw_q16 - (X_W+1)'(Q16_ONE);
    end else begin
      x_mag_w = (X_W+1)'(Q16_ONE) - raw_q16;
    end
    den_s = $signed(DENS_W'(MILLI) - DENS_W'({db_r, 1'b0}) - DENS_W'({sat_r, 1'b0}));
    // Non-positive denominator: take one, the largest gain.
    if (den_s < $signed(DENS_W'(1))) begin
      den = DEN_W'(1);
    end else begin
      den = den_s[DEN_W-1:0];
    end
  end

  assign y_num  = NUM_W'(x_mag_w[X_W-1:0]) * NUM_W'(MILLI);
  // Dead band threshold in Q16, rounded to nearest.
  assign db_num = NUM_W'({db_r, FRAC_W'(0)}) + NUM_W'(MILLI / 2);

  always_ff @(posedge clk) begin
    if (div_start) begin
      x_neg_r <= x_neg;
    end
  end

  logic [NUM_W-1:0] y_mag;
  logic [NUM_W-1:0] dbq;

  pcdh_serial_div u_div_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (y_num),
    .den   (den),
    .quo   (y_mag),
    .stat  (y_stat)
  );

  pcdh_serial_div u_div_band (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (db_num),
    .den   (DEN_W'(MILLI)),
    .quo   (dbq),
    .stat  (db_stat)
  );

  // Dead band, clamp and step scaling; hold the product-derived magnitude.
  step_mag_t sm_nxt, sm_r;

  pcdh_shaper u_shaper (
    .y_mag (y_mag),
    .dbq   (dbq),
    .neg   (x_neg_r),
    .sm    (sm_nxt)
  );

  always_ff @(posedge clk) begin
    if (scale_en) begin
      sm_r <= sm_nxt;
    end
  end

  // Hysteresis and output register.
  logic [OUT_W-1:0] step_out;
  logic [OUT_W-1:0] out_step_r;

  pcdh_hyst u_hyst (
    .clk      (clk),
    .rst_n    (rst_n),
    .sm       (sm_r),
    .commit   (commit),
    .step_out (step_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_step_r <= step_out;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TD_W'(out_step_r);

  // Checks.
  `PCDH_ASSERT_NXT(a_accept_starts_div, clk, rst_n, in_tvalid && in_tready, state_r == ST_DIV)
  `PCDH_ASSERT_IMP(a_done_in_div, clk, rst_n, y_stat.done || db_stat.done, state_r == ST_DIV)
  `PCDH_ASSERT_IMP(a_div_lockstep, clk, rst_n, state_r == ST_DIV, y_stat.busy && db_stat.busy)

endmodule
`default_nettype wire

>>> tb/pot_command_deadband_hysteresis_unit_test.sv
// Self-checking testbench for pot_command_deadband_hysteresis_unit.
// It drives raw potentiometer sums and register writes and checks every command step against
// a typed expectation or a local model of gain, dead band, clamp and hysteresis. Depends on pcdh_pkg.
`default_nettype none
module pot_command_deadband_hysteresis_unit_test;
  import pcdh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_DRAIN      = 40;
  localparam int RAW_MAX        = 8191;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_ITEMS    = 165;
  localparam int REPORT_LIMIT   = 10;

  // One row of the directed part. A row with load_regs set first writes both registers.
  // Where check_typed is set, typed_step is the expected command; otherwise the model decides.
  typedef struct packed {
    logic                    load_regs;
    logic [DB_W-1:0]         db_val;
    logic [CFG_W-1:0]        sat_val;
    logic [RAW_W-1:0]        raw;
    logic                    check_typed;
    logic signed [OUT_W-1:0] typed_step;
  } pot_row_t;

  typedef struct {
    logic signed [OUT_W-1:0] step;
    logic [RAW_W-1:0]        raw;
  } cmd_expect_t;

  localparam int ROW_COUNT = 24;

  // Reset settings first (dead band 100, saturation 20): center, both ends, the raw sum
  // above range, then both dead band edges and small steps that exercise the hold logic.
  // After that: no dead band and no margin, a non-positive gain denominator, and the
  // upper in-range extremes.
  pot_row_t pot_rows [ROW_COUNT] = '{
    '{1'b0, 9'd0,   9'd0,   13'd4096, 1'b1, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd0,    1'b1, 9'sd200},
    '{1'b0, 9'd0,   9'd0,   13'd8191, 1'b1, -9'sd200},
    '{1'b0, 9'd0,   9'd0,   13'd8190, 1'b1, -9'sd200},
    '{1'b0, 9'd0,   9'd0,   13'd4096, 1'b1, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd3785, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd3784, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd4407, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd4408, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd3769, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd3754, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd3738, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd3754, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd3769, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd8189, 1'b0, 9'sd0},
    '{1'b1, 9'd0,   9'd0,   13'd0,    1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd8191, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd4096, 1'b0, 9'sd0},
    '{1'b1, 9'd511, 9'd511, 13'd4095, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd4097, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd0,    1'b0, 9'sd0},
    '{1'b1, 9'd400, 9'd90,  13'd4100, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd3000, 1'b0, 9'sd0},
    '{1'b0, 9'd0,   9'd0,   13'd8191, 1'b0, 9'sd0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_TD_W-1:0]   in_tdata;   // [12:0] raw_sum
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_TD_W-1:0]  out_tdata;  // [8:0] command_step
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Local copy of the register file and of the remembered even step.
  logic [DB_W-1:0]         model_db;
  logic [SAT_W-1:0]        model_sat;
  logic signed [OUT_W-1:0] model_held;

  cmd_expect_t             cmd_queue [$];
  int                      err_count;

  // Typed expectation of the item currently on the input port.
  logic                    cur_typed;
  logic signed [OUT_W-1:0] cur_typed_step;

  // Idle rates of the two sides, in percent, changed per phase.
  int gap_pct;
  int stall_pct;

  pot_command_deadband_hysteresis_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Compute the command step of one raw sum and advance the remembered step.
  function automatic logic signed [OUT_W-1:0] condition_command(input logic [RAW_W-1:0] raw);
    longint x;
    longint den;
    longint dbq;
    longint y;
    longint step;
    longint diff;
    x   = longint'(Q16_ONE) - longint'(IN_SCALE) * longint'(raw);
    den = longint'(MILLI) - 2 * longint'(model_db) - 2 * longint'(model_sat);
    dbq = (longint'(model_db) * Q16_ONE + MILLI / 2) / MILLI;
    // A non-positive denominator means the largest gain.
    if (den < 1) begin
      den = 1;
    end
    y = (x * MILLI) / den;
    // Remove the dead band symmetrically, shifting the rest toward zero.
    if (y > 0) begin
      y = (y < dbq) ? 0 : y - dbq;
    end else if (y < 0) begin
      y = (y > -dbq) ? 0 : y + dbq;
    end
    if (y > Q16_ONE) begin
      y = Q16_ONE;
    end
    if (y < -Q16_ONE) begin
      y = -Q16_ONE;
    end
    step = (y * STEPS_PER_UNIT) / Q16_ONE;
    if (step > STEP_MAX) begin
      step = STEP_MAX;
    end
    if (step < -STEP_MIN_MAG) begin
      step = -STEP_MIN_MAG;
    end
    // Hold the remembered step when the new one is within the hysteresis width.
    diff = longint'(model_held) - step;
    if (diff < 0) begin
      diff = -diff;
    end
    if (diff < HYST_WIDTH) begin
      step = longint'(model_held);
    end
    model_held = OUT_W'((step / 2) * 2);
    return OUT_W'(step);
  endfunction

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endfunction

  // Scoreboard: retire results first, then queue the expectation of a newly accepted item.
  always @(posedge clk) begin
    cmd_expect_t             want;
    cmd_expect_t             entry;
    logic signed [OUT_W-1:0] got;
    logic signed [OUT_W-1:0] predicted;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_W-1:0];
        if (cmd_queue.size() == 0) begin
          flag_error($sformatf("unexpected command step %0d at %0t", got, $realtime));
        end else begin
          want = cmd_queue.pop_front();
          if (got !== want.step) begin
            flag_error($sformatf("command step mismatch for raw %0d: expected %0d, got %0d",
                                 want.raw, want.step, got));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predicted = condition_command(in_tdata[RAW_W-1:0]);
        entry.raw  = in_tdata[RAW_W-1:0];
        entry.step = cur_typed ? cur_typed_step : predicted;
        cmd_queue.push_back(entry);
      end
    end
  end

  // Result side: random stall bursts, none when stall_pct is zero.
  initial begin : ready_gen
    int hold_off;
    out_tready = 1'b0;
    hold_off = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        hold_off--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        hold_off = $urandom_range(1, 19) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // End the run when no item moves on either side for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Present one raw sum, optionally after an idle gap; called and left at a falling edge.
  // Valid stays high after the accept so that a following item goes out back to back.
  task automatic send_raw(input logic [RAW_W-1:0] raw, input logic typed,
                          input logic signed [OUT_W-1:0] typed_step);
    int gap;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid      <= 1'b1;
    in_tdata       <= {{(IN_TD_W - RAW_W){1'b0}}, raw};
    cur_typed      = typed;
    cur_typed_step = typed_step;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid and hold until every queued command has come back.
  task automatic drain_commands();
    in_tvalid <= 1'b0;
    while (cmd_queue.size() != 0) @(negedge clk);
  endtask

  // Write both registers on consecutive cycles; only called while the block is idle.
  task automatic load_registers(input logic [DB_W-1:0] db_val, input logic [CFG_W-1:0] sat_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEAD_BAND;
    cfg_wdata <= CFG_W'(db_val);
    model_db   = db_val;
    @(negedge clk);
    cfg_index <= CFG_SATURATION;
    cfg_wdata <= sat_val;
    model_sat  = sat_val[SAT_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int               raw_walk;
    int               sel;
    logic [DB_W-1:0]  db_pick;
    logic [CFG_W-1:0] sat_pick;
    logic [RAW_W-1:0] raw_pick;

    // Drive every input to a known value and load the reset state of the model.
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_DEAD_BAND;
    cfg_wdata      = '0;
    cur_typed      = 1'b0;
    cur_typed_step = '0;
    model_db       = DB_W'(DB_RESET);
    model_sat      = SAT_W'(SAT_RESET);
    model_held     = '0;
    err_count      = 0;
    gap_pct        = 30;
    stall_pct      = 30;
    raw_walk       = 4096;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the table, reprogramming where a row asks for it.
    for (int r = 0; r < ROW_COUNT; r++) begin
      if (pot_rows[r].load_regs) begin
        drain_commands();
        load_registers(pot_rows[r].db_val, pot_rows[r].sat_val);
      end
      send_raw(pot_rows[r].raw, pot_rows[r].check_typed, pot_rows[r].typed_step);
    end

    // Random part: one register setting per phase. Most items follow a slow random walk
    // so that consecutive steps land close together and the hold logic is exercised.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_commands();
      case (ph % 4)
        0: begin
          db_pick  = DB_W'($urandom_range(0, 400));
          sat_pick = CFG_W'($urandom_range(0, 90));
        end
        1: begin
          db_pick  = DB_W'($urandom);
          sat_pick = CFG_W'($urandom);
        end
        2: begin
          db_pick  = DB_W'($urandom_range(0, 30));
          sat_pick = CFG_W'($urandom_range(0, 10));
        end
        default: begin
          db_pick  = $urandom_range(0, 1) ? '1 : '0;
          sat_pick = $urandom_range(0, 1) ? '1 : '0;
        end
      endcase
      load_registers(db_pick, sat_pick);

      // Vary the idle mix per phase; the last phase runs with no idling at all.
      if (ph == PHASE_COUNT - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        sel       = $urandom_range(0, 2);
        gap_pct   = (sel == 0) ? 0 : (sel == 1) ? 20 : 60;
        sel       = $urandom_range(0, 2);
        stall_pct = (sel == 0) ? 0 : (sel == 1) ? 20 : 60;
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          raw_walk = raw_walk + $urandom_range(0, 80) - 40;
          if (raw_walk < 0) begin
            raw_walk = 0;
          end
          if (raw_walk > RAW_MAX) begin
            raw_walk = RAW_MAX;
          end
          raw_pick = RAW_W'(raw_walk);
        end else if (sel < 88) begin
          raw_pick = RAW_W'($urandom);
          raw_walk = raw_pick;
        end else begin
          case ($urandom_range(0, 3))
            0:       raw_pick = '0;
            1:       raw_pick = '1;
            2:       raw_pick = RAW_W'(4096);
            default: raw_pick = RAW_W'(RAW_MAX - 1);
          endcase
        end
        send_raw(raw_pick, 1'b0, '0);
      end
    end

    // Let the last commands come back, then give the block a latency's worth of slack
    // so that any extra result still shows up.
    drain_commands();
    repeat (END_DRAIN) @(negedge clk);
    if (cmd_queue.size() != 0) begin
      flag_error($sformatf("%0d command steps never arrived", cmd_queue.size()));
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
